// ===== hdl/jar_pkg.sv =====
// Shared types and constants for the joint angle restore unit.
// No dependencies; imported by jar_cfg, jar_calc, joint_angle_restore_unit and the bench.
`default_nettype none

package jar_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_RAW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KNOWN_POS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_POS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_POS   = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_CONFIG = 2'd1;
    localparam logic [1:0] STATUS_NO_UNIQUE  = 2'd2;

    // One full turn: 65536 counts, 360000 mdeg
    localparam int TURN_COUNTS_LOG2 = 16;
    localparam int PROD_W           = 36;   // 17-bit delta times 19-bit turn
    localparam int CAND_W           = 34;   // position plus a few turns
    localparam logic signed [PROD_W-1:0] TURN_MDEG_PROD = 36'sd360000;
    localparam logic signed [CAND_W-1:0] TURN_MDEG_CAND = 34'sd360000;

    typedef struct packed {
        logic        [15:0] zero_raw;
        logic signed [31:0] known_position_mdeg;
        logic               reverse;
        logic signed [31:0] min_position_mdeg;
        logic signed [31:0] max_position_mdeg;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] position_mdeg;
        logic        [1:0]  status;
    } res_t;

endpackage : jar_pkg

`default_nettype wire

// ===== hdl/jar_cfg.sv =====
// Configuration register file of the joint angle restore unit.
// Depends on jar_pkg for the register indexes and the cfg_t record.
`default_nettype none

module jar_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [jar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jar_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output jar_pkg::cfg_t                        cfg
);
    import jar_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one register write; unknown indexes leave everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ZERO_RAW:  cfg_next.zero_raw            = cfg_wdata[15:0];
                REG_KNOWN_POS: cfg_next.known_position_mdeg = $signed(cfg_wdata);
                REG_REVERSE:   cfg_next.reverse             = cfg_wdata[0];
                REG_MIN_POS:   cfg_next.min_position_mdeg   = $signed(cfg_wdata);
                REG_MAX_POS:   cfg_next.max_position_mdeg   = $signed(cfg_wdata);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : jar_cfg

`default_nettype wire

// ===== hdl/jar_calc.sv =====
// Combinational position restore: scale the encoder delta, build five turn
// candidates and pick the one inside the allowed window. Depends on jar_pkg.
`default_nettype none

module jar_calc (
    input  wire logic [15:0]   raw_angle,
    input  wire jar_pkg::cfg_t cfg,
    output jar_pkg::res_t      res
);
    import jar_pkg::*;

    logic        [15:0]              delta;
    logic signed [16:0]              sdelta;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        prod_biased;
    logic signed [PROD_W-TURN_COUNTS_LOG2-1:0] scaled;
    logic signed [CAND_W-1:0]        known_w;
    logic signed [CAND_W-1:0]        lo_w;
    logic signed [CAND_W-1:0]        hi_w;
    logic signed [CAND_W-1:0]        span;
    logic signed [CAND_W-1:0]        base;
    logic signed [CAND_W-1:0]        cand [5];
    logic        [4:0]               fits;
    logic signed [CAND_W-1:0]        found;
    logic                            bad_cfg;

    // Signed delta from the zero reading, half turn reads as negative before the reverse flip
    assign delta  = raw_angle - cfg.zero_raw;
    assign sdelta = cfg.reverse ? -{delta[15], delta} : {delta[15], delta};

    // Scale to mdeg; bias negative products so the shift truncates toward zero
    assign prod        = {{(PROD_W-17){sdelta[16]}}, sdelta} * TURN_MDEG_PROD;
    assign prod_biased = prod + {{(PROD_W-TURN_COUNTS_LOG2){1'b0}},
                                 {TURN_COUNTS_LOG2{prod[PROD_W-1]}}};
    assign scaled      = prod_biased[PROD_W-1:TURN_COUNTS_LOG2];

    assign known_w = {{(CAND_W-32){cfg.known_position_mdeg[31]}}, cfg.known_position_mdeg};
    assign lo_w    = {{(CAND_W-32){cfg.min_position_mdeg[31]}}, cfg.min_position_mdeg};
    assign hi_w    = {{(CAND_W-32){cfg.max_position_mdeg[31]}}, cfg.max_position_mdeg};
    assign span    = hi_w - lo_w;
    assign base    = known_w + {{(CAND_W-$bits(scaled)){scaled[$bits(scaled)-1]}}, scaled};

    // Window must hold the known position and be narrower than one turn
    assign bad_cfg = (lo_w > known_w) || (known_w > hi_w) || (span >= TURN_MDEG_CAND);

    // Candidates base - 2 turns .. base + 2 turns
    always_comb begin
        cand[0] = base - (TURN_MDEG_CAND <<< 1);
        cand[1] = base - TURN_MDEG_CAND;
        cand[2] = base;
        cand[3] = base + TURN_MDEG_CAND;
        cand[4] = base + (TURN_MDEG_CAND <<< 1);
        found   = '0;
        for (int k = 0; k < 5; k++) begin
            fits[k] = (cand[k] >= lo_w) && (cand[k] <= hi_w);
            if (fits[k]) begin
                found = found | cand[k];
            end
        end
    end

    // Status and position, zero position on any error
    always_comb begin
        priority if (bad_cfg) begin
            res.status        = STATUS_BAD_CONFIG;
            res.position_mdeg = '0;
        end else if ($countones(fits) != 1) begin
            res.status        = STATUS_NO_UNIQUE;
            res.position_mdeg = '0;
        end else begin
            res.status        = STATUS_OK;
            res.position_mdeg = found[31:0];
        end
    end

endmodule : jar_calc

`default_nettype wire

// ===== hdl/joint_angle_restore_unit.sv =====
// Top level of the joint angle restore unit: stream ports, input and result
// registers. Depends on jar_pkg, jar_cfg and jar_calc.
`default_nettype none

// Restores an absolute joint position in millidegrees from one single-turn
// 16-bit encoder reading. One reading is taken per cycle unless m_tready
// holds the pipeline: the reading lands in an input register, and one
// combinational pass (delta, constant scale, five turn candidates, window
// test) feeds the result register, which drives the result port. Sustained
// rate is one item per cycle, limited only by m_tready. Status 0 is ok, 1 a
// bad window configuration, 2 no unique candidate; the position is zero
// whenever status is nonzero. Registers are written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must do so only while no request
// is in flight, and the block itself does not enforce this.
module joint_angle_restore_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [jar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jar_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // [15:0] raw_angle
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,   // [31:0] position_mdeg
    output logic [1:0]                           m_tuser    // [1:0] status
);
    import jar_pkg::*;

    cfg_t        cfg;
    res_t        calc_res;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] raw_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        res_reg;
    logic        out_adv;

    jar_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jar_calc u_calc (
        .raw_angle (raw_reg),
        .cfg       (cfg),
        .res       (calc_res)
    );

    // Two-register pipeline; each stage moves when the one after it has room
    assign out_adv        = !out_valid_reg || m_tready;
    assign s_tready       = !in_valid_reg || out_adv;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_reg <= s_tdata;
        end
        if (out_adv && in_valid_reg) begin
            res_reg <= calc_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg.position_mdeg;
    assign m_tuser  = res_reg.status;

`ifndef ASSERT_OFF
    // Any error status carries a zero position
    a_err_zero_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tdata == 32'd0))
        else $error("error status with nonzero position");

    // An ok result lies inside the configured window
    a_ok_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STATUS_OK)) |->
        (($signed(m_tdata) >= cfg.min_position_mdeg) &&
         ($signed(m_tdata) <= cfg.max_position_mdeg)))
        else $error("ok result outside position window");

    // A held input request moves to the result register when it has room
    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv) |=> m_tvalid)
        else $error("input request lost between stages");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == STATUS_OK) || (m_tuser == STATUS_BAD_CONFIG) ||
                      (m_tuser == STATUS_NO_UNIQUE)))
        else $error("undefined status code");
`endif

endmodule : joint_angle_restore_unit

`default_nettype wire

// ===== bench/joint_angle_restore_unit_tb.sv =====
// Self-checking bench for joint_angle_restore_unit: directed and random encoder
// readings under several window settings, checked against an in-bench predictor.
// Depends on jar_pkg and the unit under test only.
`timescale 1ns / 100ps

module joint_angle_restore_unit_tb;
    import jar_pkg::*;

    localparam longint TURN_MDEG   = 360000;
    localparam longint TURN_COUNTS = 65536;
    localparam int     SEGMENTS    = 16;
    localparam int     SEG_ITEMS   = 118;
    localparam int     CYCLE_LIMIT = 200000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic [1:0]             m_tuser;

    joint_angle_restore_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cfg_t        window;          // shadow of the unit's registers
    logic [15:0] reading_q[$];    // readings waiting to be sent
    res_t        position_q[$];   // expected restored positions, oldest first
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          req_taken      = 1'b0;
    int          fail_count     = 0;
    int          cycles         = 0;
    int          n_sent         = 0;
    int          n_ok           = 0;
    int          n_bad_cfg      = 0;
    int          n_no_unique    = 0;

    // Restore one reading under the given window: the predicted result
    function automatic res_t restore_position(cfg_t w, logic [15:0] raw);
        res_t   r;
        longint kn;
        longint lo;
        longint hi;
        longint sdelta;
        longint base;
        longint cand;
        longint found;
        int     hits;
        logic [15:0] delta;
        kn    = longint'(w.known_position_mdeg);
        lo    = longint'(w.min_position_mdeg);
        hi    = longint'(w.max_position_mdeg);
        found = 0;
        hits  = 0;
        r.position_mdeg = '0;
        if (lo > kn || kn > hi || (hi - lo) >= TURN_MDEG) begin
            r.status = STATUS_BAD_CONFIG;
            return r;
        end
        delta  = raw - w.zero_raw;
        // half turn (32768) reads as the negative extreme
        sdelta = (delta <= 16'd32767) ? longint'(delta) : longint'(delta) - TURN_COUNTS;
        if (w.reverse)
            sdelta = -sdelta;
        base = kn + (sdelta * TURN_MDEG) / TURN_COUNTS;   // truncates toward zero
        for (int k = -2; k <= 2; k++) begin
            cand = base + longint'(k) * TURN_MDEG;
            if (cand >= lo && cand <= hi) begin
                found = cand;
                hits++;
            end
        end
        if (hits != 1) begin
            r.status = STATUS_NO_UNIQUE;
            return r;
        end
        r.position_mdeg = found[31:0];
        r.status        = STATUS_OK;
        return r;
    endfunction

    // Input side: predict on every accepted request; result side: check in order
    always @(posedge aclk) begin
        res_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (aresetn) begin
            req_taken = s_tvalid && s_tready;
            if (req_taken) begin
                position_q.push_back(restore_position(window, s_tdata));
                n_sent++;
            end
            if (m_tvalid && m_tready) begin
                if (position_q.size() == 0) begin
                    $error("unexpected result: position_mdeg %0d status %0d",
                           $signed(m_tdata), m_tuser);
                    fail_count++;
                end else begin
                    want = position_q.pop_front();
                    if (m_tdata !== want.position_mdeg) begin
                        $error("position_mdeg: expected %0d, got %0d",
                               want.position_mdeg, $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    case (want.status)
                        STATUS_OK:         n_ok++;
                        STATUS_BAD_CONFIG: n_bad_cfg++;
                        default:           n_no_unique++;
                    endcase
                end
            end
        end
    end

    // Driver: hold a request until taken, then maybe idle; receiver stalls at random
    always @(negedge aclk) begin
        if (!s_tvalid || req_taken) begin
            if (reading_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= reading_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_ZERO_RAW:  window.zero_raw            = data[15:0];
            REG_KNOWN_POS: window.known_position_mdeg = data;
            REG_REVERSE:   window.reverse             = data[0];
            REG_MIN_POS:   window.min_position_mdeg   = data;
            REG_MAX_POS:   window.max_position_mdeg   = data;
            default: ;     // unused index, ignored by the unit
        endcase
    endtask

    task automatic set_window(input logic [15:0] zero, input logic [31:0] known,
                              input logic rev, input logic [31:0] lo, input logic [31:0] hi);
        write_reg(REG_ZERO_RAW, {16'($urandom_range(0, 65535)), zero}); // upper bits dropped
        write_reg(REG_KNOWN_POS, known);
        write_reg(REG_REVERSE, {15'($urandom_range(0, 32767)),
                                16'($urandom_range(0, 65535)), rev});
        write_reg(REG_MIN_POS, lo);
        write_reg(REG_MAX_POS, hi);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Block until every queued request is sent and every result has come back
    task automatic drain();
        while (reading_q.size() != 0 || s_tvalid || position_q.size() != 0)
            @(posedge aclk);
    endtask

    // Random window: mostly sane, sometimes near the 32-bit extremes, sometimes bad
    task automatic random_window();
        longint kn;
        longint lo;
        longint hi;
        longint width;
        int     pick;
        pick = $urandom_range(0, 5);
        kn   = longint'(signed'($urandom));
        if (pick == 0)
            kn = 64'sd2147483647 - $urandom_range(0, 400000);
        else if (pick == 1)
            kn = -64'sd2147483648 + $urandom_range(0, 400000);
        case ($urandom_range(0, 3))
            0, 1:    width = $urandom_range(359000, 359999);
            2:       width = $urandom_range(180000, 359999);
            default: width = $urandom_range(0, 359999);
        endcase
        lo = kn - $urandom_range(0, int'(width));
        if (lo < -64'sd2147483648)
            lo = -64'sd2147483648;
        hi = lo + width;
        if (hi > 64'sd2147483647) begin
            hi = 64'sd2147483647;
            lo = hi - width;
        end
        if (pick == 5) begin
            lo = longint'(signed'($urandom));
            hi = longint'(signed'($urandom));
        end
        set_window(16'($urandom_range(0, 65535)), kn[31:0], 1'($urandom_range(0, 1)),
                   lo[31:0], hi[31:0]);
        // an unused index must leave the registers alone
        write_reg(CFG_INDEX_W'(REG_MAX_POS + 1 + $urandom_range(0, 2)), $urandom);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [15:0] z;
        window = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset window [0,0]: only the zero reading lands exactly on it
        reading_q = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
        drain();

        // wide window, forward then reversed, including the half-turn difference
        z = 16'h1234;
        for (int rev = 0; rev < 2; rev++) begin
            set_window(z, 32'sd90000, rev[0], -32'sd179999, 32'sd180000);
            reading_q = '{z, z + 16'd32767, z + 16'd32768, 16'h0000, 16'hFFFF};
            drain();
        end

        // bad windows: min above known, known above max, exactly one turn wide
        set_window(16'h0, 32'sd10, 1'b0, 32'sd11, 32'sd100);
        reading_q.push_back(16'h4000);
        drain();
        set_window(16'h0, 32'sd101, 1'b0, 32'sd11, 32'sd100);
        reading_q.push_back(16'h4000);
        drain();
        set_window(16'h0, 32'sd0, 1'b0, -32'sd180000, 32'sd180000);
        reading_q.push_back(16'h4000);
        drain();
        // full 32-bit span must not overflow the width check
        set_window(16'h0, 32'sd0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        reading_q.push_back(16'h0000);
        drain();

        // windows at the top and bottom of the position range
        set_window(16'hFFFF, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF - 32'd359999, 32'h7FFF_FFFF);
        reading_q = '{16'hFFFF, 16'h7FFF, 16'h7FFE};
        drain();
        set_window(16'h0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000 + 32'd359999);
        reading_q = '{16'h0000, 16'h8000, 16'h0001};
        drain();

        // random part: fresh window per segment, idling pattern rotates
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            random_window();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int i = 0; i < SEG_ITEMS; i++) begin
                // some readings sit near the zero reading or half a turn off
                if ($urandom_range(0, 7) == 0)
                    reading_q.push_back(window.zero_raw + 16'($urandom_range(32766, 32770)));
                else if ($urandom_range(0, 7) == 0)
                    reading_q.push_back(window.zero_raw + 16'($urandom_range(0, 4)) - 16'd2);
                else
                    reading_q.push_back(16'($urandom));
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (position_q.size() != 0) begin
            $error("%0d expected results never arrived", position_q.size());
            fail_count++;
        end
        $display("Covered %0d readings over %0d windows: %0d ok, %0d bad window, %0d no unique",
                 n_sent, SEGMENTS + 9, n_ok, n_bad_cfg, n_no_unique);
        $display("Idle patterns: none, sender 50%%, receiver 50%%, both 34%%");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jar_pkg.sv
hdl/jar_cfg.sv
hdl/jar_calc.sv
hdl/joint_angle_restore_unit.sv
bench/joint_angle_restore_unit_tb.sv
